// ===== rtl/tclp_pkg.sv =====
package tclp_pkg;

    // Field and state widths
    localparam int BYTE_W = 8;
    localparam int CNT_W = 6;
    localparam int STEP_W = 10;
    localparam int DUTY_W = 7;
    localparam int CMP_W = 16;
    localparam int ACC_W = 7;
    localparam int NUM_W = 10;
    localparam int CAND_N = 4;

    // Default for the character limit of one command
    localparam int MAX_CHARS_DEF = 49;

    // Length of the "PWM:" prefix; the number starts right after it
    localparam int PREFIX_LEN = 4;

    // Reset values
    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd33;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;

    // Number limits: the magnitude saturates one above the largest legal duty
    localparam logic [ACC_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [ACC_W-1:0] NUM_SAT = 7'd101;

    // Candidate bits of the match flags
    localparam int CAND_ON = 0;
    localparam int CAND_OFF = 1;
    localparam int CAND_PWM = 2;
    localparam int CAND_STATUS = 3;

    // Bytes that are dropped before counting
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    // Blanks skipped ahead of the number
    localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_VT = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF = 8'h0C;

    typedef enum logic [2:0] {
        REPLY_ON,
        REPLY_OFF,
        REPLY_DUTY,
        REPLY_STATUS,
        REPLY_INVALID
    } reply_kind_t;

    typedef enum logic [1:0] {
        NUM_SIGN,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef enum logic {
        CFG_TERMINATOR,
        CFG_COMPARE_STEP
    } cfg_index_t;

    // Result of one terminator beat, handed from the parser to the top level
    typedef struct packed {
        logic                valid;
        reply_kind_t         kind;
        logic                led;
        logic [DUTY_W-1:0]   duty;
    } tclp_result_t;

    // Returns the candidates that survive character c at position pos.
    // Bit order follows the CAND_* constants: {Status, PWM:, OFF, ON}.
    function automatic logic [CAND_N-1:0] word_match(
        input logic [CNT_W-1:0]  pos,
        input logic [BYTE_W-1:0] c
    );
        logic [CAND_N-1:0] keep;
        keep = '0;
        case (pos)
            CNT_W'(0): keep = {c == "S", c == "P", c == "O", c == "O"};
            CNT_W'(1): keep = {c == "t", c == "W", c == "F", c == "N"};
            CNT_W'(2): keep = {c == "a", c == "M", c == "F", 1'b0};
            CNT_W'(3): keep = {c == "t", c == ":", 1'b0, 1'b0};
            CNT_W'(4): keep = {c == "u", 1'b1, 1'b0, 1'b0};
            CNT_W'(5): keep = {c == "s", 1'b1, 1'b0, 1'b0};
            // Past every word: only the PWM prefix stays alive
            default:   keep = 4'b0100;
        endcase
        return keep;
    endfunction

endpackage

// ===== rtl/tclp_parser.sv =====
module tclp_parser #(
    parameter int MAX_CHARS = tclp_pkg::MAX_CHARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          beat_valid,
    input  logic [tclp_pkg::BYTE_W-1:0]   beat_byte,
    input  logic [tclp_pkg::BYTE_W-1:0]   terminator,
    output tclp_pkg::tclp_result_t        result
);
    import tclp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CHARS);

    logic [CNT_W-1:0]  char_count_reg;
    logic [CAND_N-1:0] match_flags_reg;
    num_phase_t        phase_reg;
    num_phase_t        phase_next;
    logic              negative_reg;
    logic              negative_next;
    logic [ACC_W-1:0]  accum_reg;
    logic [ACC_W-1:0]  accum_next;
    logic              lamp_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic              is_term;
    logic              is_blank;
    logic              counted;
    logic              num_en;
    logic              is_digit;
    logic              is_ws;
    logic [NUM_W-1:0]  acc_wide;
    logic [ACC_W-1:0]  acc_sat;
    logic              num_ok;

    // Byte classes
    assign is_term  = (beat_byte == terminator);
    assign is_blank = (beat_byte == CHAR_CR) || (beat_byte == CHAR_LF)
                      || (beat_byte == CHAR_SPACE);
    assign counted  = !is_term && !is_blank && (char_count_reg < CNT_LIMIT);
    assign num_en   = counted && (char_count_reg >= CNT_W'(PREFIX_LEN));
    assign is_digit = (beat_byte >= "0") && (beat_byte <= "9");
    assign is_ws    = (beat_byte == CHAR_TAB) || (beat_byte == CHAR_VT)
                      || (beat_byte == CHAR_FF);

    // Decimal accumulate, saturating so that any overflow stays out of range
    assign acc_wide = NUM_W'(accum_reg) * NUM_W'(10)
                      + NUM_W'(beat_byte[3:0]);
    assign acc_sat  = (acc_wide > NUM_W'(NUM_SAT)) ? NUM_SAT : acc_wide[ACC_W-1:0];

    // A negative sign is only legal on a zero magnitude
    assign num_ok = (accum_reg <= DUTY_MAX) && (!negative_reg || (accum_reg == '0));

    // Number parser next state
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        accum_next    = accum_reg;
        case (phase_reg)
            NUM_SIGN:
            begin
                if (is_ws)
                begin
                    phase_next = NUM_SIGN;
                end
                else if ((beat_byte == "+") || (beat_byte == "-"))
                begin
                    negative_next = (beat_byte == "-");
                    phase_next    = NUM_DIGITS;
                end
                else if (is_digit)
                begin
                    phase_next = NUM_DIGITS;
                    accum_next = acc_sat;
                end
                else
                begin
                    phase_next = NUM_DONE;
                end
            end
            NUM_DIGITS:
            begin
                if (is_digit)
                begin
                    accum_next = acc_sat;
                end
                else
                begin
                    phase_next = NUM_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Command decision at the terminator
    always_comb
    begin
        result.valid = 1'b0;
        result.kind  = REPLY_INVALID;
        result.led   = lamp_reg;
        result.duty  = duty_reg;
        if (beat_valid && is_term)
        begin
            result.valid = 1'b1;
            if (match_flags_reg[CAND_ON] && (char_count_reg == CNT_W'(2)))
            begin
                result.kind = REPLY_ON;
                result.led  = 1'b1;
            end
            else if (match_flags_reg[CAND_OFF] && (char_count_reg == CNT_W'(3)))
            begin
                result.kind = REPLY_OFF;
                result.led  = 1'b0;
            end
            else if (match_flags_reg[CAND_PWM]
                     && (char_count_reg >= CNT_W'(PREFIX_LEN)))
            begin
                result.kind  = REPLY_DUTY;
                result.valid = num_ok;
                if (num_ok)
                begin
                    result.duty = accum_reg;
                end
            end
            else if (match_flags_reg[CAND_STATUS] && (char_count_reg == CNT_W'(6)))
            begin
                result.kind = REPLY_STATUS;
            end
            else
            begin
                result.kind = REPLY_INVALID;
            end
        end
    end

    // Parse state and lamp settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= '0;
            match_flags_reg <= '1;
            phase_reg       <= NUM_SIGN;
            negative_reg    <= 1'b0;
            accum_reg       <= '0;
            lamp_reg        <= 1'b0;
            duty_reg        <= DUTY_RESET;
        end
        else if (beat_valid)
        begin
            if (is_term)
            begin
                char_count_reg  <= '0;
                match_flags_reg <= '1;
                phase_reg       <= NUM_SIGN;
                negative_reg    <= 1'b0;
                accum_reg       <= '0;
                lamp_reg        <= result.led;
                duty_reg        <= result.duty;
            end
            else if (counted)
            begin
                char_count_reg  <= char_count_reg + CNT_W'(1);
                match_flags_reg <= match_flags_reg & word_match(char_count_reg, beat_byte);
                if (num_en)
                begin
                    phase_reg    <= phase_next;
                    negative_reg <= negative_next;
                    accum_reg    <= accum_next;
                end
            end
        end
    end

endmodule

// ===== rtl/text_command_lamp_pwm_parser.sv =====
// Channel  Signals                                      Direction
// -------  -------------------------------------------  ---------
// in       in_valid, in_stall, rx_byte                  byte in
// out      out_valid, out_stall, reply_kind, led_on,    reply out
//          duty_percent, compare_value
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    register write
//
// One byte is taken per cycle while in_stall is low; a byte passes through an
// input register and is parsed from there, and any reply sits in the output
// register after it. A terminator's reply is loaded into the output register at
// the edge at which the terminator leaves the input register.
// Reset puts the terminator at '!', the step at 10, the lamp off and duty 50.
// Only a terminator waits behind a stalled reply; other bytes keep flowing.
module text_command_lamp_pwm_parser #(
    parameter int MAX_CHARS = tclp_pkg::MAX_CHARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tclp_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    reply_kind,
    output logic                          led_on,
    output logic [tclp_pkg::DUTY_W-1:0]   duty_percent,
    output logic [tclp_pkg::CMP_W-1:0]    compare_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tclp_pkg::STEP_W-1:0]   cfg_data
);
    import tclp_pkg::*;

    localparam int PROD_W = DUTY_W + STEP_W;

    logic [BYTE_W-1:0] terminator_reg;
    logic [STEP_W-1:0] step_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              out_valid_reg;
    reply_kind_t       kind_reg;
    logic              led_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [CMP_W-1:0]  compare_reg;
    logic [CMP_W-1:0]  compare_next;

    logic              term_held;
    logic              out_free;
    logic              advance;
    logic              in_take;
    logic [PROD_W-1:0] product;
    tclp_result_t      result;

    // Flow control: a held terminator moves only when the reply slot frees up
    assign term_held = (in_byte_reg == terminator_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && (!term_held || out_free);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg <= TERM_RESET;
            step_reg       <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TERMINATOR:   terminator_reg <= cfg_data[BYTE_W-1:0];
                CFG_COMPARE_STEP: step_reg <= cfg_data;
                default:          step_reg <= step_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_take || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    tclp_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (advance),
        .beat_byte  (in_byte_reg),
        .terminator (terminator_reg),
        .result     (result)
    );

    // Timer compare: duty times step while lit, saturated to the field width
    assign product = PROD_W'(result.duty) * PROD_W'(step_reg);

    always_comb
    begin
        if (!result.led)
        begin
            compare_next = '0;
        end
        else if (|product[PROD_W-1:CMP_W])
        begin
            compare_next = '1;
        end
        else
        begin
            compare_next = product[CMP_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            kind_reg    <= result.kind;
            led_reg     <= result.led;
            duty_reg    <= result.duty;
            compare_reg <= compare_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply_kind    = kind_reg;
    assign led_on        = led_reg;
    assign duty_percent  = duty_reg;
    assign compare_value = compare_reg;

`ifndef SYNTH
    // A stall is only raised while a byte sits in the input register.
    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A terminator never overwrites a reply that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && term_held && out_valid_reg && out_stall) |-> in_stall)
        else $error("terminator advanced over a pending reply");

    // A dark lamp always reports a zero compare value.
    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !led_on) |-> (compare_value == '0))
        else $error("nonzero compare with lamp off");

    // The reported duty never leaves the legal range.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_MAX))
        else $error("duty out of range");

    // An ON reply always reports a lit lamp.
    a_on_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (reply_kind == REPLY_ON)) |-> led_on)
        else $error("ON reply with lamp off");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import tclp_pkg::*;

    localparam int STEP_MAX = 655;

    // One reply beat as the block presents it
    typedef struct packed {
        reply_kind_t         kind;
        logic                led;
        logic [DUTY_W-1:0]   duty;
        logic [CMP_W-1:0]    cmp;
    } lamp_reply_t;

    // One row of the directed part; typed rows carry a reply written out by hand
    typedef struct packed {
        logic [BYTE_W-1:0]   b;
        logic                typed;
        lamp_reply_t         want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             reply_kind;
    logic                   led_on;
    logic [DUTY_W-1:0]      duty_percent;
    logic [CMP_W-1:0]       compare_value;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [STEP_W-1:0]      cfg_data;

    // Mirror of the parser state and its two registers
    logic [BYTE_W-1:0]      term_char;
    logic [STEP_W-1:0]      step;
    logic [CNT_W-1:0]       kept;
    logic [CAND_N-1:0]      alive;
    num_phase_t             num_phase;
    logic                   num_neg;
    logic [ACC_W-1:0]       num_mag;
    logic                   lamp;
    logic [DUTY_W-1:0]      duty;

    lamp_reply_t            replies_due[$];
    stim_row_t              stim_rows[$];
    logic [BYTE_W-1:0]      cmd_bytes[$];
    int                     fail_count;
    bit                     calm;

    text_command_lamp_pwm_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_kind    (reply_kind),
        .led_on        (led_on),
        .duty_percent  (duty_percent),
        .compare_value (compare_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Drop the parse state after a terminator or at reset.
    function automatic void clear_parse();
        kept = '0;
        alive = '1;
        num_phase = NUM_SIGN;
        num_neg = 1'b0;
        num_mag = '0;
    endfunction

    // A word stays alive while each kept character matches it in place.
    // Past its end only a prefix word survives.
    function automatic bit word_alive(string w, bit is_prefix, int pos,
                                      logic [BYTE_W-1:0] c);
        if (pos < w.len())
            return c == w[pos];
        return is_prefix;
    endfunction

    // Number after the PWM prefix: blanks, one sign, then digits that saturate.
    function automatic void take_number_char(logic [BYTE_W-1:0] c);
        bit digit;
        int v;
        digit = (c >= "0" && c <= "9");
        if (num_phase == NUM_SIGN) begin
            if (c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)
                return;
            if (c == "+" || c == "-") begin
                num_neg = (c == "-");
                num_phase = NUM_DIGITS;
                return;
            end
            num_phase = digit ? NUM_DIGITS : NUM_DONE;
        end
        if (num_phase != NUM_DIGITS)
            return;
        if (!digit) begin
            num_phase = NUM_DONE;
            return;
        end
        v = int'(num_mag) * 10 + (int'(c) - int'("0"));
        num_mag = (v > int'(NUM_SAT)) ? NUM_SAT : ACC_W'(v);
    endfunction

    // Advance the command parser by one byte; returns 1 when a reply is due.
    function automatic bit parse_byte(input logic [BYTE_W-1:0] c, output lamp_reply_t r);
        int prod;
        r = '0;
        if (c != term_char) begin
            if (c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE)
                return 0;
            if (kept < MAX_CHARS_DEF) begin
                alive[CAND_ON] = alive[CAND_ON] & word_alive("ON", 0, kept, c);
                alive[CAND_OFF] = alive[CAND_OFF] & word_alive("OFF", 0, kept, c);
                alive[CAND_PWM] = alive[CAND_PWM] & word_alive("PWM:", 1, kept, c);
                alive[CAND_STATUS] = alive[CAND_STATUS] & word_alive("Status", 0, kept, c);
                if (kept >= PREFIX_LEN)
                    take_number_char(c);
                kept = kept + 1'b1;
            end
            return 0;
        end

        if (alive[CAND_ON] && kept == 2) begin
            lamp = 1'b1;
            r.kind = REPLY_ON;
        end else if (alive[CAND_OFF] && kept == 3) begin
            lamp = 1'b0;
            r.kind = REPLY_OFF;
        end else if (alive[CAND_PWM] && kept >= PREFIX_LEN) begin
            // Out of range, or negative with a nonzero magnitude: silently ignored
            if (num_mag > DUTY_MAX || (num_neg && num_mag != 0)) begin
                clear_parse();
                return 0;
            end
            duty = num_mag;
            r.kind = REPLY_DUTY;
        end else if (alive[CAND_STATUS] && kept == 6) begin
            r.kind = REPLY_STATUS;
        end else begin
            r.kind = REPLY_INVALID;
        end
        clear_parse();

        prod = lamp ? int'(duty) * int'(step) : 0;
        r.led = lamp;
        r.duty = duty;
        r.cmp = (prod > 65535) ? '1 : CMP_W'(prod);
        return 1;
    endfunction

    // Offer one byte beat; the parser mirror advances when the beat is taken.
    // Entered and left at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input lamp_reply_t typed_reply);
        lamp_reply_t r;
        while (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (parse_byte(b, r))
            replies_due.push_back(typed ? typed_reply : r);
        @(negedge clk);
    endtask

    // Register write once the block has drained its work.
    task automatic write_reg(input cfg_index_t idx, input logic [STEP_W-1:0] val);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        // A rejected duty command leaves no reply behind, so give the pipe time
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_TERMINATOR)
            term_char = val[BYTE_W-1:0];
        else
            step = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] b);
        stim_rows.push_back('{b: b, typed: 1'b0, want: '0});
    endtask

    task automatic add_row_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i]);
    endtask

    // Terminator row with the reply read straight off the command
    task automatic add_row_end(input reply_kind_t k, input logic led,
                               input int d, input int cmp);
        lamp_reply_t w;
        w.kind = k;
        w.led = led;
        w.duty = DUTY_W'(d);
        w.cmp = CMP_W'(cmp);
        stim_rows.push_back('{b: TERM_RESET, typed: 1'b1, want: w});
    endtask

    // Command characters, now and then with a dropped byte in front
    task automatic add_char(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(2))
                0: cmd_bytes.push_back(CHAR_CR);
                1: cmd_bytes.push_back(CHAR_LF);
                default: cmd_bytes.push_back(CHAR_SPACE);
            endcase
        end
        cmd_bytes.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // Build one random command line: mostly well formed, some broken or noise.
    task automatic build_command();
        int pick;
        int n;
        cmd_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 12) begin
            add_str("ON");
        end else if (pick < 22) begin
            add_str("OFF");
        end else if (pick < 30) begin
            add_str("Status");
        end else if (pick < 66) begin
            add_str("PWM:");
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(2))
                        0: add_char(CHAR_TAB);
                        1: add_char(CHAR_VT);
                        default: add_char(CHAR_FF);
                    endcase
                end
            end
            n = $urandom_range(9);
            if (n < 2)
                add_char("-");
            else if (n < 4)
                add_char("+");
            case ($urandom_range(9))
                0, 1, 2, 3, 4: add_str($sformatf("%0d", $urandom_range(100)));
                5: add_str($sformatf("%0d", $urandom_range(101, 999)));
                6: add_str($sformatf("%0d", $urandom_range(99999)));
                7: add_str($sformatf("00%0d", $urandom_range(20)));
                8: add_str("100");
                default: ;
            endcase
            if ($urandom_range(4) == 0) begin
                add_char(BYTE_W'($urandom_range(255)));
                add_char("3");
            end
        end else if (pick < 76) begin
            // Near misses of the real commands
            case ($urandom_range(5))
                0: add_str("on");
                1: add_str("Off");
                2: add_str("PWM5");
                3: add_str("Stat");
                4: add_str("ONN");
                default: add_str("Statuss");
            endcase
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 6))
                add_char(BYTE_W'($urandom_range(255)));
        end else if (pick < 95) begin
            // Long runs that may pass the character limit
            if ($urandom_range(1) == 0)
                add_str("PWM:");
            else
                add_str("Status");
            repeat ($urandom_range(40, 60))
                add_char("0" + BYTE_W'($urandom_range(9)));
        end
        // Empty lines fall through with just the terminator
        if ($urandom_range(19) != 0)
            cmd_bytes.push_back(term_char);
    endtask

    // Reply checker
    always @(posedge clk) begin : check_replies
        lamp_reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply kind %0d led %0b duty %0d cmp %0d",
                         $time, reply_kind, led_on, duty_percent, compare_value);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if ({reply_kind, led_on, duty_percent, compare_value} !== want) begin
                    $display("%0t: reply mismatch, expected kind %0d led %0b duty %0d cmp %0d",
                             $time, want.kind, want.led, want.duty, want.cmp);
                    $display("%0t:                 actual kind %0d led %0b duty %0d cmp %0d",
                             $time, reply_kind, led_on, duty_percent, compare_value);
                    fail_count++;
                end
            end
        end
    end

    // Reply side back-pressure
    always @(negedge clk) begin
        if (rst_n)
            out_stall <= !calm && ($urandom_range(99) < 11);
    end

    initial begin
        int sent;
        logic [BYTE_W-1:0] t;
        logic [STEP_W-1:0] s;

        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TERMINATOR;
        cfg_data = '0;
        fail_count = 0;
        calm = 1'b0;
        term_char = TERM_RESET;
        step = STEP_RESET;
        lamp = 1'b0;
        duty = DUTY_RESET;
        clear_parse();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed commands under the reset settings
        add_row_text("ON");
        add_row_end(REPLY_ON, 1'b1, 50, 500);
        add_row_text("PWM:100");
        add_row_end(REPLY_DUTY, 1'b1, 100, 1000);
        add_row_text("Status");
        add_row_end(REPLY_STATUS, 1'b1, 100, 1000);
        add_row_text("OFF");
        add_row_end(REPLY_OFF, 1'b0, 100, 0);
        add_row(8'h00);
        add_row(8'hFF);
        add_row_end(REPLY_INVALID, 1'b0, 100, 0);
        foreach (stim_rows[i])
            send_byte(stim_rows[i].b, stim_rows[i].typed, stim_rows[i].want);

        // Random command traffic under a series of register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin t = CHAR_CR;    s = STEP_W'(STEP_MAX); end
                1: begin t = CHAR_LF;    s = '0;                end
                2: begin t = CHAR_SPACE; s = STEP_W'(1);        end
                3: begin t = 8'h00;      s = STEP_W'($urandom_range(STEP_MAX)); end
                4: begin t = 8'hFF;      s = STEP_W'(STEP_MAX); end
                5: begin t = BYTE_W'($urandom_range(255)); s = STEP_W'($urandom_range(STEP_MAX)); end
                6: begin t = "#";        s = STEP_W'(100);      end
                default: begin t = TERM_RESET; s = STEP_RESET; end
            endcase
            write_reg(CFG_TERMINATOR, {2'($urandom_range(3)), t});
            write_reg(CFG_COMPARE_STEP, s);
            calm = (ph == 3);
            sent = 0;
            while (sent < 250) begin
                build_command();
                foreach (cmd_bytes[i]) begin
                    send_byte(cmd_bytes[i], 1'b0, '0);
                    if (cmd_bytes[i] == term_char ||
                        !(cmd_bytes[i] == CHAR_CR || cmd_bytes[i] == CHAR_LF ||
                          cmd_bytes[i] == CHAR_SPACE))
                        sent++;
                end
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("** text_command_lamp_pwm_parser: PASSED **");
        else
            $display("** text_command_lamp_pwm_parser: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #(8 * 500000);
        $display("** text_command_lamp_pwm_parser: FAILED **");
        $finish;
    end

endmodule
